### design/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and codes for the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

    typedef enum logic [2:0] {
        FUNC_PUT      = 3'd0,
        FUNC_GET      = 3'd1,
        FUNC_CONTAINS = 3'd2,
        FUNC_REMOVE   = 3'd3,
        FUNC_CLEAR    = 3'd4
    } func_t;

    localparam logic [10:0] MAX_ENTRIES_RESET = 11'd1000;
    localparam int          REG_MAX_ENTRIES   = 0;

endpackage
`default_nettype wire

### design/lkvc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

### design/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value store with least-recently-used replacement
// ----------------------------------------------------------------------------
// requests enter on s_axis (tuser = func, tdata = key then value), one result
// leaves on m_axis (tuser = {evicted, hit}, tdata = read_value then occupancy).
// the limit max_entries sits at apb address 0 and is taken only while empty.
// slots live in one ram (valid, key, payload, newer and older link); each
// put, get, contains or remove scans the ram one slot per cycle for the key,
// and a get or put that hits also relinks its slot. a put that misses adds
// a second scan for a free slot plus link read-modify-write steps, after
// evicting the oldest entry when the limit is reached. clear invalidates
// one slot per cycle. one request is in flight at a time.
// after reset a clearing pass over every slot runs before s_axis_tready
// rises. a stalled receiver holds the result in the output register and
// s_axis_tready stays low until that result is taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [127:0]  s_axis_tdata,   // key[63:0], value[127:64]
    input  wire logic [2:0]    s_axis_tuser,   // func
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [79:0]        m_axis_tdata,   // read_value[63:0], occupancy[74:64]
    output logic [1:0]         m_axis_tuser,   // hit[0], evicted[1]
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = 1 + KEY_BITS + VALUE_BITS + 2 * AW;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [12:0] {
        ST_INIT   = 13'b0000000000001,
        ST_IDLE   = 13'b0000000000010,
        ST_SCAN   = 13'b0000000000100,
        ST_FOUND  = 13'b0000000001000,
        ST_FREE   = 13'b0000000010000,
        ST_LNK_RD = 13'b0000000100000,
        ST_LNK_WT = 13'b0000001000000,
        ST_LNK_WR = 13'b0000010000000,
        ST_SLOT   = 13'b0000100000000,
        ST_APP_RD = 13'b0001000000000,
        ST_APP_WT = 13'b0010000000000,
        ST_APP_WR = 13'b0100000000000,
        ST_DONE   = 13'b1000000000000
    } state_t;

    // ram record fields
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] payload;
        logic [AW-1:0]         newer;
        logic [AW-1:0]         older;
    } rec_t;

    state_t state_reg, state_next;
    logic [AW:0]   ptr_reg, ptr_next;        // scan address, extra bit = done
    logic          rd_ok_reg, rd_ok_next;    // ram data valid for ptr-1
    logic [AW-1:0] rd_adr_reg, rd_adr_next;
    logic [2:0]    func_reg, func_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [AW-1:0] slot_reg, slot_next;      // target slot
    rec_t          rec_reg, rec_next;        // target record copy
    logic [AW-1:0] lnk_reg, lnk_next;        // neighbor being patched
    logic          lnk_side_reg, lnk_side_next; // 0: patch older's newer, 1: newer's older
    logic          app_reg, app_next;        // relink after unlink
    logic          drop_reg, drop_next;      // invalidate target
    logic          evict_pass_reg, evict_pass_next;
    logic [AW-1:0] oldest_reg, oldest_next, newest_reg, newest_next;
    logic [CW-1:0] count_reg, count_next;
    logic [10:0]   max_reg;
    logic          hit_reg, hit_next, ev_reg, ev_next;
    logic [VALUE_BITS-1:0] rv_reg, rv_next;

    logic          ov_reg, ov_next;
    logic [79:0]   odata_reg, odata_next;
    logic [1:0]    ouser_reg, ouser_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    rec_t          ram_wdata, ram_rdata;
    logic [RW-1:0] ram_rbits;

    logic          tail_fix_reg;

    lkvc_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rbits)
    );
    assign ram_rdata = rec_t'(ram_rbits);

    // effective limit
    logic [CW-1:0] lim;
    always_comb
    begin
        if (max_reg == 11'd0)
            lim = CW'(1);
        else if (32'(max_reg) > 32'(CAPACITY))
            lim = CAP_C;
        else
            lim = CW'(max_reg);
    end

    // apb
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'(4 * lkvc_pkg::REG_MAX_ENTRIES));
    assign prdata = (paddr == 3'(4 * lkvc_pkg::REG_MAX_ENTRIES)) ? {21'd0, max_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= lkvc_pkg::MAX_ENTRIES_RESET;
        else if (cfg_wr && count_reg == '0)
            max_reg <= pwdata[10:0];
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        rd_ok_next = 1'b0;
        rd_adr_next = rd_adr_reg;
        func_next = func_reg;
        key_next = key_reg;
        val_next = val_reg;
        slot_next = slot_reg;
        rec_next = rec_reg;
        lnk_next = lnk_reg;
        lnk_side_next = lnk_side_reg;
        app_next = app_reg;
        drop_next = drop_reg;
        evict_pass_next = evict_pass_reg;
        oldest_next = oldest_reg;
        newest_next = newest_reg;
        count_next = count_reg;
        hit_next = hit_reg;
        ev_next = ev_reg;
        rv_next = rv_reg;
        ov_next = ov_reg;
        odata_next = odata_reg;
        ouser_next = ouser_reg;
        ram_we = 1'b0;
        ram_addr = ptr_reg[AW-1:0];
        ram_wdata = rec_reg;

        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                ram_we = 1'b1;
                ram_wdata = '0;
                ptr_next = ptr_reg + (AW + 1)'(1);
                if (ptr_reg[AW-1:0] == AW'(CAPACITY - 1))
                begin
                    // a clear request reports once the pass is over
                    state_next = (func_reg == 3'(lkvc_pkg::FUNC_CLEAR)) ? ST_DONE : ST_IDLE;
                    ptr_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    func_next = s_axis_tuser;
                    key_next = s_axis_tdata[KEY_BITS-1:0];
                    val_next = s_axis_tdata[64 +: VALUE_BITS];
                    hit_next = 1'b0;
                    ev_next = 1'b0;
                    rv_next = '0;
                    ptr_next = '0;
                    app_next = 1'b0;
                    drop_next = 1'b0;
                    evict_pass_next = 1'b0;
                    case (s_axis_tuser)
                        lkvc_pkg::FUNC_PUT, lkvc_pkg::FUNC_GET,
                        lkvc_pkg::FUNC_CONTAINS, lkvc_pkg::FUNC_REMOVE:
                            state_next = ST_SCAN;
                        lkvc_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                            oldest_next = '0;
                            newest_next = '0;
                            state_next = ST_INIT;
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN, ST_FREE:
            begin
                // issue reads ptr; check data of the previous address
                ram_addr = ptr_reg[AW-1:0];
                if (!ptr_reg[AW])
                begin
                    ptr_next = ptr_reg + (AW + 1)'(1);
                    rd_ok_next = 1'b1;
                    rd_adr_next = ptr_reg[AW-1:0];
                end
                if (rd_ok_reg && state_reg == ST_SCAN &&
                    ram_rdata.valid && ram_rdata.key == key_reg)
                begin
                    slot_next = rd_adr_reg;
                    rec_next = ram_rdata;
                    rd_ok_next = 1'b0;
                    hit_next = (func_reg != 3'(lkvc_pkg::FUNC_PUT)) || !evict_pass_reg;
                    state_next = ST_FOUND;
                end
                else if (rd_ok_reg && state_reg == ST_FREE && !ram_rdata.valid)
                begin
                    slot_next = rd_adr_reg;
                    rd_ok_next = 1'b0;
                    state_next = ST_SLOT;
                end
                else if (ptr_reg[AW] && !rd_ok_reg)
                begin
                    // scan ended without a match
                    if (state_reg == ST_FREE)
                        state_next = ST_DONE;
                    else if (func_reg == 3'(lkvc_pkg::FUNC_PUT))
                    begin
                        if (count_reg >= lim && count_reg != '0)
                        begin
                            // evict the oldest: read it, then unlink and drop
                            ev_next = 1'b1;
                            slot_next = oldest_reg;
                            evict_pass_next = 1'b1;
                            ptr_next = {1'b0, oldest_reg};
                            state_next = ST_FOUND;
                            rec_next.valid = 1'b0;
                        end
                        else
                        begin
                            ptr_next = '0;
                            state_next = ST_FREE;
                        end
                    end
                    else
                        state_next = ST_DONE;
                end
            end
            ST_FOUND:
            begin
                if (evict_pass_reg && !rec_reg.valid)
                begin
                    // fetch the victim record
                    ram_addr = slot_reg;
                    rec_next.valid = 1'b1;
                    state_next = ST_LNK_WT;
                    lnk_side_next = 1'b1;
                    drop_next = 1'b1;
                end
                else
                begin
                    case (func_reg)
                        lkvc_pkg::FUNC_PUT:
                        begin
                            rec_next.payload = val_reg;
                            app_next = 1'b1;
                            state_next = ST_LNK_RD;
                        end
                        lkvc_pkg::FUNC_GET:
                        begin
                            rv_next = rec_reg.payload;
                            app_next = 1'b1;
                            state_next = ST_LNK_RD;
                        end
                        lkvc_pkg::FUNC_REMOVE:
                        begin
                            drop_next = 1'b1;
                            state_next = ST_LNK_RD;
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_LNK_WT:
            begin
                // victim record arrives
                rec_next = ram_rdata;
                state_next = ST_LNK_RD;
            end
            ST_LNK_RD:
            begin
                // unlink slot: patch neighbors one at a time
                if (count_reg > CW'(1))
                begin
                    if (slot_reg == oldest_reg)
                        oldest_next = rec_reg.newer;
                    if (slot_reg == newest_reg)
                        newest_next = rec_reg.older;
                    if (slot_reg != oldest_reg)
                    begin
                        lnk_next = rec_reg.older;
                        lnk_side_next = 1'b0;
                        ram_addr = rec_reg.older;
                        state_next = ST_LNK_WR;
                    end
                    else if (slot_reg != newest_reg)
                    begin
                        lnk_next = rec_reg.newer;
                        lnk_side_next = 1'b1;
                        ram_addr = rec_reg.newer;
                        state_next = ST_LNK_WR;
                    end
                    else
                        state_next = ST_SLOT;
                end
                else
                    state_next = ST_SLOT;
                if (count_reg != '0)
                    count_next = count_reg - CW'(1);
            end
            ST_LNK_WR:
            begin
                // read-modify-write of neighbor lnk
                ram_addr = lnk_reg;
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
                if (!lnk_side_reg)
                    ram_wdata.newer = rec_reg.newer;
                else
                    ram_wdata.older = rec_reg.older;
                // newest already moved to the older neighbor when the target was newest
                if (!lnk_side_reg && newest_reg != rec_reg.older)
                begin
                    lnk_next = rec_reg.newer;
                    lnk_side_next = 1'b1;
                    state_next = ST_APP_WT;
                end
                else
                    state_next = ST_SLOT;
            end
            ST_APP_WT:
            begin
                // read the newer neighbor
                ram_addr = lnk_reg;
                state_next = ST_LNK_WR;
            end
            ST_SLOT:
            begin
                ram_addr = slot_reg;
                if (drop_reg)
                begin
                    ram_we = 1'b1;
                    ram_wdata = rec_reg;
                    ram_wdata.valid = 1'b0;
                    if (evict_pass_reg)
                    begin
                        drop_next = 1'b0;
                        ptr_next = '0;
                        state_next = ST_FREE;
                    end
                    else
                        state_next = ST_DONE;
                end
                else if (app_reg || evict_pass_reg)
                begin
                    if (evict_pass_reg && !app_reg)
                    begin
                        rec_next.valid = 1'b1;
                        rec_next.key = key_reg;
                        rec_next.payload = val_reg;
                    end
                    state_next = ST_APP_RD;
                end
                else
                begin
                    // put into free slot without eviction
                    rec_next.valid = 1'b1;
                    rec_next.key = key_reg;
                    rec_next.payload = val_reg;
                    state_next = ST_APP_RD;
                end
            end
            ST_APP_RD:
            begin
                // write the target as newest
                ram_addr = slot_reg;
                ram_we = 1'b1;
                ram_wdata = rec_reg;
                ram_wdata.older = newest_reg;
                if (count_reg == '0)
                begin
                    oldest_next = slot_reg;
                    newest_next = slot_reg;
                    count_next = CW'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    lnk_next = newest_reg;
                    newest_next = slot_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ST_APP_WR;
                end
            end
            ST_APP_WR:
            begin
                // read old newest
                ram_addr = lnk_reg;
                state_next = ST_DONE;
                lnk_side_next = 1'b0;
                app_next = 1'b0;
                drop_next = 1'b1;
            end
            ST_DONE:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next = 1'b1;
                    ouser_next = {ev_reg, hit_reg};
                    odata_next = '0;
                    odata_next[VALUE_BITS-1:0] = rv_reg;
                    odata_next[64 +: CW] = count_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // finish append: patch old newest's newer link
        if (state_reg == ST_DONE && app_reg == 1'b0 && drop_reg && lnk_side_reg == 1'b0 &&
            tail_fix_reg)
        begin
            ram_we = 1'b1;
            ram_addr = lnk_reg;
            ram_wdata = ram_rdata;
            ram_wdata.newer = slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tail_fix_reg <= 1'b0;
        else
            tail_fix_reg <= (state_reg == ST_APP_WR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ptr_reg <= '0;
            rd_ok_reg <= 1'b0;
            func_reg <= '0;
            oldest_reg <= '0;
            newest_reg <= '0;
            count_reg <= '0;
            ov_reg <= 1'b0;
            app_reg <= 1'b0;
            drop_reg <= 1'b0;
            evict_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            rd_ok_reg <= rd_ok_next;
            func_reg <= func_next;
            oldest_reg <= oldest_next;
            newest_reg <= newest_next;
            count_reg <= count_next;
            ov_reg <= ov_next;
            app_reg <= app_next;
            drop_reg <= drop_next;
            evict_pass_reg <= evict_pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_adr_reg <= rd_adr_next;
        key_reg <= key_next;
        val_reg <= val_next;
        slot_reg <= slot_next;
        rec_reg <= rec_next;
        lnk_reg <= lnk_next;
        lnk_side_reg <= lnk_side_next;
        hit_reg <= hit_next;
        ev_reg <= ev_next;
        rv_reg <= rv_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    // occupancy never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_C)
        else $error("occupancy above capacity");
    // no request taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) ov_reg |-> !s_axis_tready)
        else $error("ready while result pending");
    // a result leaves only from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == ST_DONE))
        else $error("result without done");

endmodule
`default_nettype wire

### bench/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// checks the lru cache against a queue-based recency model: directed corner
// requests, then random phases over several occupancy limits, random gaps on
// both stream sides and limit writes between phases
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

    localparam int CAPACITY = 1024;

    typedef struct {
        logic [2:0]  func;
        logic [63:0] key;
        logic [63:0] value;
    } cache_req_t;

    typedef struct {
        logic        hit;
        logic [63:0] read_value;
        logic        evicted;
        logic [10:0] occupancy;
    } cache_rsp_t;

    typedef struct {
        logic [63:0] key;
        logic [63:0] payload;
    } entry_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata = '0;   // key[63:0], value[127:64]
    logic [2:0]    s_axis_tuser = '0;   // func
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [79:0]   m_axis_tdata;        // read_value[63:0], occupancy[74:64]
    logic [1:0]    m_axis_tuser;        // hit[0], evicted[1]
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    lru_key_value_cache dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // recency order: front is the least recently used entry
    entry_t      recency_q[$];
    logic [10:0] limit_reg = lkvc_pkg::MAX_ENTRIES_RESET;
    cache_req_t  pending_req_q[$];
    cache_rsp_t  expected_rsp_q[$];
    int          errors = 0;
    bit          steady = 1'b0;
    logic [63:0] key_pool[12];

    function automatic int find_entry(logic [63:0] k);
        foreach (recency_q[i])
            if (recency_q[i].key == k)
                return i;
        return -1;
    endfunction

    function automatic cache_rsp_t predict_cache(cache_req_t r);
        cache_rsp_t rsp;
        entry_t     e;
        int         idx;
        int         lim;
        rsp = '{1'b0, 64'd0, 1'b0, 11'd0};
        lim = (limit_reg == 0) ? 1 : (limit_reg > CAPACITY ? CAPACITY : limit_reg);
        idx = find_entry(r.key);
        case (r.func)
            lkvc_pkg::FUNC_PUT:
            begin
                if (idx >= 0)
                begin
                    rsp.hit = 1'b1;
                    recency_q.delete(idx);
                end
                else if (recency_q.size() >= lim)
                begin
                    rsp.evicted = 1'b1;
                    void'(recency_q.pop_front());
                end
                e.key = r.key;
                e.payload = r.value;
                recency_q.push_back(e);
            end
            lkvc_pkg::FUNC_GET:
            begin
                if (idx >= 0)
                begin
                    rsp.hit = 1'b1;
                    e = recency_q[idx];
                    rsp.read_value = e.payload;
                    recency_q.delete(idx);
                    recency_q.push_back(e);
                end
            end
            lkvc_pkg::FUNC_CONTAINS:
                rsp.hit = (idx >= 0);
            lkvc_pkg::FUNC_REMOVE:
            begin
                if (idx >= 0)
                begin
                    rsp.hit = 1'b1;
                    recency_q.delete(idx);
                end
            end
            lkvc_pkg::FUNC_CLEAR:
                recency_q.delete();
            default:
                ;
        endcase
        rsp.occupancy = 11'(recency_q.size());
        return rsp;
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 200);
    endfunction

    // request driver
    int send_gap = 0;
    always @(posedge clk)
    begin
        cache_req_t r;
        bit         taken;
        taken = s_axis_tvalid && s_axis_tready;
        if (taken)
        begin
            r.func = s_axis_tuser;
            r.key = s_axis_tdata[63:0];
            r.value = s_axis_tdata[127:64];
            expected_rsp_q.push_back(predict_cache(r));
        end
        if (!s_axis_tvalid || taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_req_q.size() > 0)
            begin
                r = pending_req_q.pop_front();
                s_axis_tdata <= {r.value, r.key};
                s_axis_tuser <= r.func;
                s_axis_tvalid <= 1'b1;
                send_gap = next_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result monitor
    int stall_left = 0;
    always @(posedge clk)
    begin
        cache_rsp_t exp_rsp;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
            end
            else
            begin
                exp_rsp = expected_rsp_q.pop_front();
                if (m_axis_tuser[0] !== exp_rsp.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp_rsp.hit, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata[63:0] !== exp_rsp.read_value)
                begin
                    $error("read_value: expected %h, got %h",
                           exp_rsp.read_value, m_axis_tdata[63:0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== exp_rsp.evicted)
                begin
                    $error("evicted: expected %0d, got %0d",
                           exp_rsp.evicted, m_axis_tuser[1]);
                    errors++;
                end
                if (m_axis_tdata[74:64] !== exp_rsp.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d",
                           exp_rsp.occupancy, m_axis_tdata[74:64]);
                    errors++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left = next_gap();
        end
    end

    task automatic reg_write(input int index, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(index * 4);
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // the limit is only taken while the cache is empty
        if (index == lkvc_pkg::REG_MAX_ENTRIES && recency_q.size() == 0)
            limit_reg = data[10:0];
    endtask

    task automatic queue_req(input logic [2:0] f, input logic [63:0] k,
                             input logic [63:0] v);
        cache_req_t r;
        r.func = f;
        r.key = k;
        r.value = v;
        pending_req_q.push_back(r);
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_req_q.size() > 0 || s_axis_tvalid || expected_rsp_q.size() > 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        logic [2:0]  f;
        logic [63:0] k;
        int          r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 42)      f = lkvc_pkg::FUNC_PUT;
            else if (r < 66) f = lkvc_pkg::FUNC_GET;
            else if (r < 78) f = lkvc_pkg::FUNC_CONTAINS;
            else if (r < 92) f = lkvc_pkg::FUNC_REMOVE;
            else if (r < 95) f = lkvc_pkg::FUNC_CLEAR;
            else             f = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, 11)];
            else
                k = {$urandom, $urandom};
            queue_req(f, k, {$urandom, $urandom});
        end
    endtask

    localparam logic [63:0] ONES = '1;

    initial
    begin
        int limits[8];
        limits = '{0, 1, 3, 5, 32'hFFFF_FFFF, 1024, 4, 2};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners under a limit of two
        reg_write(lkvc_pkg::REG_MAX_ENTRIES, 2);
        steady = 1'b1;
        queue_req(lkvc_pkg::FUNC_GET, 64'd0, ONES);
        queue_req(lkvc_pkg::FUNC_PUT, 64'd0, 64'd0);
        queue_req(lkvc_pkg::FUNC_PUT, ONES, ONES);
        queue_req(lkvc_pkg::FUNC_GET, 64'd0, 64'd0);
        queue_req(lkvc_pkg::FUNC_PUT, 64'd1, 64'h5555_AAAA_5555_AAAA);
        queue_req(lkvc_pkg::FUNC_CONTAINS, ONES, 64'd0);
        queue_req(lkvc_pkg::FUNC_CONTAINS, 64'd1, 64'd0);
        queue_req(lkvc_pkg::FUNC_PUT, 64'd2, 64'h1234);
        queue_req(lkvc_pkg::FUNC_GET, ONES, 64'd0);
        queue_req(lkvc_pkg::FUNC_PUT, 64'd2, ONES);
        queue_req(lkvc_pkg::FUNC_GET, 64'd2, 64'd0);
        queue_req(3'd5, 64'd2, ONES);
        queue_req(3'd6, 64'd2, ONES);
        queue_req(3'd7, 64'd2, ONES);
        queue_req(lkvc_pkg::FUNC_REMOVE, 64'd2, 64'd0);
        queue_req(lkvc_pkg::FUNC_REMOVE, 64'd2, 64'd0);
        queue_req(lkvc_pkg::FUNC_CLEAR, 64'd0, 64'd0);
        queue_req(lkvc_pkg::FUNC_GET, 64'd1, 64'd0);
        queue_req(lkvc_pkg::FUNC_PUT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        drain();

        // limit writes that must not take: other index, and cache not empty
        reg_write(1, 1);
        reg_write(lkvc_pkg::REG_MAX_ENTRIES, 7);
        queue_req(lkvc_pkg::FUNC_CLEAR, 64'd0, 64'd0);
        drain();

        foreach (limits[p])
        begin
            reg_write(lkvc_pkg::REG_MAX_ENTRIES, limits[p]);
            foreach (key_pool[i])
                key_pool[i] = {$urandom, $urandom};
            steady = (p == 2);
            queue_random(70);
            if ($urandom_range(0, 3) != 0)
                queue_req(lkvc_pkg::FUNC_CLEAR, 64'd0, 64'd0);
            drain();
        end

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_lru_key_value_cache OK");
        else
            $display("tb_lru_key_value_cache NOT OK");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("tb_lru_key_value_cache NOT OK");
        $finish;
    end

endmodule

### files.f
design/lkvc_pkg.sv
design/lkvc_ram.sv
design/lru_key_value_cache.sv
bench/tb_lru_key_value_cache.sv
